// File: rtl/sha_pkg.sv
package sha_pkg;

  localparam int COUNT_BITS_DEF = 61;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef struct packed {
    logic [31:0] a, b, c, d, e, f, g, h;
  } vars_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic vars_t sha_round(input vars_t v, input logic [31:0] kw);
    logic [31:0] s1, s0, t1, t2;
    vars_t o;
    s1 = rotr(v.e, 6) ^ rotr(v.e, 11) ^ rotr(v.e, 25);
    s0 = rotr(v.a, 2) ^ rotr(v.a, 13) ^ rotr(v.a, 22);
    t1 = v.h + s1 + ((v.e & v.f) ^ (~v.e & v.g)) + kw;
    t2 = s0 + ((v.a & v.b) ^ (v.a & v.c) ^ (v.b & v.c));
    o.h = v.g; o.g = v.f; o.f = v.e; o.e = v.d + t1;
    o.d = v.c; o.c = v.b; o.b = v.a; o.a = t1 + t2;
    sha_round = o;
  endfunction

endpackage

// File: rtl/sha_core.sv
// Compression engine: block in a 16-entry memory, copied on start into a shift window.
module sha_core
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        ld_we,
  input  logic [3:0]  ld_addr,
  input  logic [31:0] ld_data,
  input  vars_t       chain_in,
  output vars_t       chain_out,
  output logic        done
);
  logic [31:0] wmem [16];
  logic [31:0] w_r [16];
  vars_t       v_r, v_nxt;
  logic [6:0]  rnd_r;
  logic        busy_r, fin_r;
  logic [31:0] wt, lo0, lo1;
  logic [5:0]  ri;

  // Window of 16 words held as shift line; memory holds loaded block.
  always_ff @(posedge clk) begin
    if (ld_we) wmem[ld_addr] <= ld_data;
  end

  assign ri  = rnd_r[5:0];
  assign lo0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
  assign lo1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
  assign wt  = (ri < 6'd16) ? w_r[0] : (lo1 + w_r[9] + lo0 + w_r[0]);
  assign v_nxt = sha_round(v_r, ROUND_K[ri] + wt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      rnd_r  <= '0;
    end else begin
      fin_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
        v_r    <= chain_in;
        for (int i = 0; i < 16; i++) w_r[i] <= wmem[i];
      end else if (busy_r) begin
        v_r <= v_nxt;
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= wt;
        rnd_r <= rnd_r + 7'd1;
        if (rnd_r == 7'd63) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  assign chain_out.a = chain_in.a + v_r.a;
  assign chain_out.b = chain_in.b + v_r.b;
  assign chain_out.c = chain_in.c + v_r.c;
  assign chain_out.d = chain_in.d + v_r.d;
  assign chain_out.e = chain_in.e + v_r.e;
  assign chain_out.f = chain_in.f + v_r.f;
  assign chain_out.g = chain_in.g + v_r.g;
  assign chain_out.h = chain_in.h + v_r.h;
  assign done = fin_r;
endmodule

// File: rtl/sha256_message_digest_top.sv
// SHA-256, one message byte per request.
// A byte is taken each cycle while the input is open; a full block then stalls the input
//   during compression (start, 64 rounds, write-back).
// Final byte: one or two compressions, then 8 digest words.
// Reset (rst_n low, synchronous): chaining value to initial hash, count to zero.
module sha256_message_digest_top
  import sha_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic        out_digest_last
);
  typedef enum logic [5:0] {
    S_IN   = 6'b000001,
    S_CMP  = 6'b000010,
    S_PAD  = 6'b000100,
    S_PCMP = 6'b001000,
    S_OUT  = 6'b010000,
    S_WAIT = 6'b100000
  } state_t;

  state_t                  st_r;
  logic [COUNT_BITS-1:0]   cnt_r;
  logic [63:0]             len_r;
  vars_t                   h_r, h_new;
  logic [23:0]             acc_r;
  logic [5:0]              pos_r;
  logic                    fin_r, extra_r, start_r;
  logic [2:0]              oi_r;
  logic                    ld_we;
  logic [3:0]              ld_addr;
  logic [31:0]             ld_data;
  logic [7:0]              pb;
  logic                    done;
  logic [255:0]            hv;
  logic                    acc;

  assign in_ready = (st_r == S_IN);
  assign acc      = in_valid && in_ready;

  // Padding byte for position pos_r
  always_comb begin
    if (!extra_r && pos_r == cnt_r[5:0]) pb = PAD_BYTE;
    else if (pos_r >= 6'd56 && !(extra_r == 1'b0 && cnt_r[5:0] >= 6'd56))
      pb = len_r[8*(7-pos_r[2:0]) +: 8];
    else pb = 8'h00;
  end

  always_comb begin
    ld_we   = 1'b0;
    ld_addr = pos_r[5:2];
    ld_data = {acc_r, in_msg_byte};
    if (acc && pos_r[1:0] == 2'b11) ld_we = 1'b1;
    if (st_r == S_PAD && pos_r[1:0] == 2'b11) begin
      ld_we   = 1'b1;
      ld_data = {acc_r, pb};
    end
  end

  sha_core u_core (
    .clk, .rst_n, .start(start_r), .ld_we, .ld_addr, .ld_data,
    .chain_in(h_r), .chain_out(h_new), .done
  );

  assign hv = h_r;
  assign out_valid       = (st_r == S_OUT);
  assign out_digest_word = hv[255 - 32*oi_r -: 32];
  assign out_digest_last = (oi_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IN;
      cnt_r   <= '0;
      pos_r   <= '0;
      h_r     <= {INIT_H[0], INIT_H[1], INIT_H[2], INIT_H[3],
                  INIT_H[4], INIT_H[5], INIT_H[6], INIT_H[7]};
      start_r <= 1'b0;
      fin_r   <= 1'b0;
      extra_r <= 1'b0;
      oi_r    <= '0;
    end else begin
      start_r <= 1'b0;
      case (st_r)
        S_IN: if (acc) begin
          acc_r <= {acc_r[15:0], in_msg_byte};
          cnt_r <= cnt_r + 1'b1;
          pos_r <= pos_r + 6'd1;
          fin_r <= in_final_byte;
          len_r <= 64'({cnt_r + 1'b1}) << 3;
          extra_r <= 1'b0;
          if (pos_r == 6'd63) begin
            start_r <= 1'b1;
            st_r    <= S_CMP;
          end else if (in_final_byte) begin
            st_r <= S_PAD;
          end
        end
        S_CMP: if (done) begin
          h_r  <= h_new;
          st_r <= fin_r ? S_PAD : S_IN;
        end
        S_PAD: begin
          acc_r <= {acc_r[15:0], pb};
          pos_r <= pos_r + 6'd1;
          if (pos_r == 6'd63) begin
            start_r <= 1'b1;
            st_r    <= S_PCMP;
          end
        end
        S_PCMP: if (done) begin
          h_r <= h_new;
          if (!extra_r && cnt_r[5:0] >= 6'd56) begin
            extra_r <= 1'b1;
            st_r    <= S_PAD;
          end else begin
            st_r <= S_OUT;
            oi_r <= '0;
          end
        end
        S_OUT: if (out_ready) begin
          oi_r <= oi_r + 3'd1;
          if (oi_r == 3'd7) begin
            st_r  <= S_IN;
            cnt_r <= '0;
            pos_r <= '0;
            fin_r <= 1'b0;
            h_r   <= {INIT_H[0], INIT_H[1], INIT_H[2], INIT_H[3],
                      INIT_H[4], INIT_H[5], INIT_H[6], INIT_H[7]};
          end
        end
        S_WAIT: st_r <= S_IN;
        default: st_r <= S_IN;
      endcase
    end
  end

  a_last_eight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_digest_last |=> in_ready)
    else $error("digest did not end message");
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> !in_ready)
    else $error("input open during compression");
  a_block_pos: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> pos_r == 6'd0)
    else $error("compression started mid block");
endmodule

// File: verif/tb_sha256_message_digest_top.sv
module tb_sha256_message_digest_top;
  import sha_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  class digest_scoreboard;
    logic [31:0] hash_state [8];
    logic [7:0]  blk [64];
    logic [COUNT_BITS_DEF-1:0] nbytes;
    logic [32:0] pending_words [$];
    int mismatches;

    function new();
      mismatches = 0;
      clear_msg();
    endfunction

    function void clear_msg();
      for (int i = 0; i < 8; i++) hash_state[i] = INIT_H[i];
      nbytes = '0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, g, h, wt, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++)
        w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
      e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
      for (int i = 0; i < 64; i++) begin
        if (i < 16) begin
          wt = w[i];
        end else begin
          s0 = ror(w[(i-15)&15], 7) ^ ror(w[(i-15)&15], 18) ^ (w[(i-15)&15] >> 3);
          s1 = ror(w[(i-2)&15], 17) ^ ror(w[(i-2)&15], 19) ^ (w[(i-2)&15] >> 10);
          wt = s1 + w[(i-7)&15] + s0 + w[i&15];
          w[i&15] = wt;
        end
        t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
             + ROUND_K[i] + wt;
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endfunction

    function void note_request(logic [7:0] data, logic fin);
      int pos;
      logic [63:0] bit_len;
      pos = nbytes[5:0];
      blk[pos] = data;
      nbytes = nbytes + 1'b1;
      if (pos == 63) compress();
      if (!fin) return;
      pos = nbytes[5:0];
      bit_len = 64'(nbytes) << 3;
      blk[pos] = PAD_BYTE;
      pos++;
      if (pos > 56) begin
        while (pos < 64) begin blk[pos] = 8'h00; pos++; end
        compress();
        pos = 0;
      end
      while (pos < 56) begin blk[pos] = 8'h00; pos++; end
      for (int i = 0; i < 8; i++) blk[56+i] = bit_len[63-8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) pending_words.push_back({i == 7, hash_state[i]});
      clear_msg();
    endfunction

    function void check_word(logic [31:0] word, logic last);
      logic [32:0] exp_w;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h last %b", word, last);
        return;
      end
      exp_w = pending_words.pop_front();
      if (exp_w !== {last, word}) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word mismatch: exp %h last %b, got %h last %b",
                   exp_w[31:0], exp_w[32], word, last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_msg_byte = '0;
  logic in_final_byte = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic out_digest_last;

  digest_scoreboard sb = new();
  int hold_off_cycles = 0;

  sha256_message_digest_top i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int gap_len();
    if ($urandom_range(9) == 0) return $urandom_range(40, 10);
    if ($urandom_range(2) == 0) return 0;
    return $urandom_range(3);
  endfunction

  task automatic send_byte(logic [7:0] b, logic fin, bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_msg_byte <= b;
    in_final_byte <= fin;
    do @(posedge clk); while (!in_ready);
    sb.note_request(b, fin);
  endtask

  task automatic send_message(int len, int kind, bit no_gap);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: b = 8'h00;
        1: b = 8'hff;
        default: b = $urandom_range(255);
      endcase
      send_byte(b, i == len - 1, no_gap);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_word(out_digest_word, out_digest_last);
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int g;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      g = ($urandom_range(3) == 0) ? gap_len() : 0;
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    int len;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_message(1, 0, 0);
    send_message(1, 1, 0);
    send_message(3, 2, 0);
    send_message(1, 2, 0);
    send_message(1, 2, 0);
    drain();
    send_message(120, 2, 1);
    send_message(64, 0, 0);
    drain();
    hold_off_cycles = 400;
    for (int i = 0; i < 5; i++) send_message(2, 2, 1);
    drain();
    for (int i = 0; i < 6; i++) begin
      len = $urandom_range(1, 6);
      send_message(len, $urandom_range(5) == 0 ? $urandom_range(1) : 2, 0);
      if ($urandom_range(3) == 0) drain();
    end
    drain();
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
